// ===== design/tpm_pkg.sv =====
// ----------------------------------------------------------------------------
// tpm_pkg: shared definitions for the trie pattern matcher
// Table sizes, field widths, the request and operation codes, and the
// classified work item passed from the front end to the back end.
// ----------------------------------------------------------------------------
package tpm_pkg;

    // Table sizes.
    localparam int NODE_COUNT   = 4096;
    localparam int LETTER_COUNT = 26;
    localparam int SLOT_COUNT   = NODE_COUNT * LETTER_COUNT;

    // Field and index widths.
    localparam int LETTER_W   = 5;
    localparam int ID_W       = 10;
    localparam int NODE_W     = $clog2(NODE_COUNT);
    localparam int NODE_CNT_W = $clog2(NODE_COUNT + 1);
    localparam int SLOT_W     = $clog2(SLOT_COUNT);

    // Depth of the queue between the front end and the back end.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Request type codes on the input channel.
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_SCAN   = 1'b1;

    // Operation classes decided by the front end.
    typedef enum logic [1:0] {
        OP_INSERT      = 2'd0,
        OP_INSERT_SKIP = 2'd1,
        OP_SCAN        = 2'd2,
        OP_SCAN_MISS   = 2'd3
    } item_op_t;

    typedef struct packed {
        item_op_t            op;
        logic [LETTER_W-1:0] letter;
        logic                first;
        logic                last;
        logic [ID_W-1:0]     pattern_id;
    } work_item_t;

endpackage

// ===== design/trie_pattern_match.sv =====
// ----------------------------------------------------------------------------
// trie_pattern_match: multi-pattern matcher on a trie held in a node table
// Insert letters grow the trie and tag pattern ends; scan letters walk it.
// ----------------------------------------------------------------------------
// Each input transfer gives exactly one result transfer, in order. An item
// that reaches the trie passes through the engine in order: a child table
// read, a read of the candidate node's link and tag, then the decision and any
// allocation writes. A skipped item, or one on a stopped walk, is answered
// from the idle state. These dependent memory reads set the rate; a two-entry
// queue in front and a result register behind let the input and the output
// stall on their own. No clearing pass runs after reset: nodes are validated
// against the allocation count and a back link written when they are created.
module trie_pattern_match (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_req_type,
    input  logic [tpm_pkg::LETTER_W-1:0] s_letter,
    input  logic                         s_first_letter,
    input  logic                         s_last_letter,
    input  logic [tpm_pkg::ID_W-1:0]     s_pattern_id,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_match_valid,
    output logic [tpm_pkg::ID_W-1:0]     m_match_id,
    output logic                         m_walk_ended,
    output logic                         m_table_full
);
    import tpm_pkg::*;

    logic       q_valid;
    logic       q_pop;
    work_item_t q_item;

    // Front end: input transfers and classification queue.
    tpm_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_letter       (s_letter),
        .s_first_letter (s_first_letter),
        .s_last_letter  (s_last_letter),
        .s_pattern_id   (s_pattern_id),
        .q_valid        (q_valid),
        .q_item         (q_item),
        .q_pop          (q_pop)
    );

    // Back end: trie engine and result register.
    tpm_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_match_valid (m_match_valid),
        .m_match_id    (m_match_id),
        .m_walk_ended  (m_walk_ended),
        .m_table_full  (m_table_full)
    );

endmodule

// ===== design/tpm_front.sv =====
// ----------------------------------------------------------------------------
// tpm_front: input side of the trie pattern matcher
// Accepts input transfers, classifies each item by type and letter range,
// and holds the items in a short queue for the back end.
// ----------------------------------------------------------------------------
module tpm_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_req_type,
    input  logic [tpm_pkg::LETTER_W-1:0] s_letter,
    input  logic                         s_first_letter,
    input  logic                         s_last_letter,
    input  logic [tpm_pkg::ID_W-1:0]     s_pattern_id,
    output logic                         q_valid,
    output tpm_pkg::work_item_t          q_item,
    input  logic                         q_pop
);
    import tpm_pkg::*;

    work_item_t          queue_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    work_item_t          new_item;
    logic                push;
    logic                in_range;

    // Classify the incoming letter.
    always_comb begin
        in_range            = (int'(s_letter) < LETTER_COUNT);
        new_item.letter     = s_letter;
        new_item.first      = s_first_letter;
        new_item.last       = s_last_letter;
        new_item.pattern_id = s_pattern_id;
        if (s_req_type == REQ_SCAN) begin
            new_item.op = in_range ? OP_SCAN : OP_SCAN_MISS;
        end else begin
            new_item.op = in_range ? OP_INSERT : OP_INSERT_SKIP;
        end
    end

    assign s_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign push    = s_valid & s_ready;
    assign q_valid = (count_reg != '0);
    assign q_item  = queue_reg[rd_ptr_reg];

    // Queue pointer and fill count update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                    : wr_ptr_reg + 1'b1;
        end
        if (q_pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                    : rd_ptr_reg + 1'b1;
        end
        if (push && !q_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && q_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage carries payload only.
    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= new_item;
        end
    end

endmodule

// ===== design/tpm_back.sv =====
// ----------------------------------------------------------------------------
// tpm_back: trie engine of the trie pattern matcher
// Walks and grows the trie held in the child table, tags pattern end nodes,
// and drives the result register.
// ----------------------------------------------------------------------------
module tpm_back (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     q_valid,
    input  tpm_pkg::work_item_t      q_item,
    output logic                     q_pop,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic                     m_match_valid,
    output logic [tpm_pkg::ID_W-1:0] m_match_id,
    output logic                     m_walk_ended,
    output logic                     m_table_full
);
    import tpm_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_CHILD = 3'b010,
        ST_LINK  = 3'b100
    } back_state_t;

    // Each node records the parent and letter it was created for. A child
    // table entry counts only if its node is allocated and points back.
    typedef struct packed {
        logic [NODE_W-1:0]   parent;
        logic [LETTER_W-1:0] letter;
    } node_link_t;

    typedef struct packed {
        logic            tag_valid;
        logic [ID_W-1:0] id;
    } node_tag_t;

    // Memories: no reset; node entries are written when a node is allocated.
    logic [NODE_W-1:0] child_mem [SLOT_COUNT];
    node_link_t        link_mem  [NODE_COUNT];
    node_tag_t         tag_mem   [NODE_COUNT];

    back_state_t             state_reg, state_next;
    logic [NODE_W-1:0]       cursor_reg, cursor_next;
    logic                    stopped_reg, stopped_next;
    logic [NODE_CNT_W-1:0]   nodes_used_reg, nodes_used_next;
    work_item_t              item_reg, item_next;
    logic [SLOT_W-1:0]       slot_reg, slot_next;
    logic [NODE_W-1:0]       child_rd_reg;
    node_link_t              link_rd_reg;
    node_tag_t               tag_rd_reg;
    logic                    child_ok_reg, child_ok_next;

    logic                    m_valid_reg, m_valid_next;
    logic                    m_match_valid_reg;
    logic [ID_W-1:0]         m_match_id_reg;
    logic                    m_walk_ended_reg;
    logic                    m_table_full_reg;

    logic                    out_free;
    logic                    res_load;
    logic                    res_match, res_ended, res_full;
    logic [ID_W-1:0]         res_id;
    logic [NODE_W-1:0]       cur_eff;
    logic                    stp_eff;
    logic                    child_rd_en;
    logic                    child_wr_en;
    logic                    link_wr_en;
    logic                    tag_wr_en;
    logic [NODE_W-1:0]       tag_wr_addr;
    node_tag_t               tag_wr_data;
    logic [NODE_W-1:0]       new_node;
    logic                    hit;
    node_link_t              want_link;

    assign out_free = !m_valid_reg || m_ready;
    assign new_node = nodes_used_reg[NODE_W-1:0];
    assign want_link.parent = cursor_reg;
    assign want_link.letter = item_reg.letter;
    assign hit = child_ok_reg && (link_rd_reg == want_link);

    // Sequencer for one item.
    always_comb begin
        state_next      = state_reg;
        cursor_next     = cursor_reg;
        stopped_next    = stopped_reg;
        nodes_used_next = nodes_used_reg;
        item_next       = item_reg;
        slot_next       = slot_reg;
        child_ok_next   = child_ok_reg;
        q_pop           = 1'b0;
        res_load        = 1'b0;
        res_match       = 1'b0;
        res_id          = '0;
        res_ended       = 1'b0;
        res_full        = 1'b0;
        child_rd_en     = 1'b0;
        child_wr_en     = 1'b0;
        link_wr_en      = 1'b0;
        tag_wr_en       = 1'b0;
        tag_wr_addr     = new_node;
        tag_wr_data     = '0;
        cur_eff         = q_item.first ? '0 : cursor_reg;
        stp_eff         = q_item.first ? 1'b0 : stopped_reg;

        case (state_reg)
            ST_IDLE: begin
                if (q_valid && out_free) begin
                    q_pop        = 1'b1;
                    item_next    = q_item;
                    cursor_next  = cur_eff;
                    stopped_next = stp_eff;
                    slot_next    = SLOT_W'(SLOT_W'(cur_eff) * SLOT_W'(LETTER_COUNT))
                                 + SLOT_W'(q_item.letter);
                    case (q_item.op)
                        OP_INSERT: begin
                            if (stp_eff) begin
                                res_load = 1'b1;
                                res_full = 1'b1;
                            end else begin
                                child_rd_en = 1'b1;
                                state_next  = ST_CHILD;
                            end
                        end
                        OP_INSERT_SKIP: begin
                            res_load = 1'b1;
                            res_full = stp_eff;
                        end
                        OP_SCAN: begin
                            if (stp_eff) begin
                                res_load  = 1'b1;
                                res_ended = 1'b1;
                            end else begin
                                child_rd_en = 1'b1;
                                state_next  = ST_CHILD;
                            end
                        end
                        OP_SCAN_MISS: begin
                            stopped_next = 1'b1;
                            res_load     = 1'b1;
                            res_ended    = 1'b1;
                        end
                        default: begin
                            res_load = 1'b1;
                        end
                    endcase
                end
            end

            ST_CHILD: begin
                // The link and tag of the candidate child are read now.
                child_ok_next = (child_rd_reg != '0)
                             && (NODE_CNT_W'(child_rd_reg) < nodes_used_reg);
                state_next    = ST_LINK;
            end

            ST_LINK: begin
                res_load   = 1'b1;
                state_next = ST_IDLE;
                if (item_reg.op == OP_SCAN) begin
                    if (hit) begin
                        cursor_next = child_rd_reg;
                        res_match   = tag_rd_reg.tag_valid;
                        res_id      = tag_rd_reg.tag_valid ? tag_rd_reg.id : '0;
                    end else begin
                        stopped_next = 1'b1;
                        res_ended    = 1'b1;
                    end
                end else if (hit) begin
                    cursor_next = child_rd_reg;
                    if (item_reg.last) begin
                        tag_wr_en             = 1'b1;
                        tag_wr_addr           = child_rd_reg;
                        tag_wr_data.tag_valid = 1'b1;
                        tag_wr_data.id        = item_reg.pattern_id;
                    end
                end else if (nodes_used_reg < NODE_CNT_W'(NODE_COUNT)) begin
                    // Allocate a new node and clear or set its tag.
                    child_wr_en           = 1'b1;
                    link_wr_en            = 1'b1;
                    tag_wr_en             = 1'b1;
                    tag_wr_addr           = new_node;
                    tag_wr_data.tag_valid = item_reg.last;
                    tag_wr_data.id        = item_reg.last ? item_reg.pattern_id : '0;
                    nodes_used_next       = nodes_used_reg + 1'b1;
                    cursor_next           = new_node;
                end else begin
                    stopped_next = 1'b1;
                    res_full     = 1'b1;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cursor_reg     <= '0;
            stopped_reg    <= 1'b0;
            nodes_used_reg <= NODE_CNT_W'(1);
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cursor_reg     <= cursor_next;
            stopped_reg    <= stopped_next;
            nodes_used_reg <= nodes_used_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Item and lookup payload registers.
    always_ff @(posedge aclk) begin
        item_reg     <= item_next;
        slot_reg     <= slot_next;
        child_ok_reg <= child_ok_next;
    end

    // Child table memory.
    always_ff @(posedge aclk) begin
        if (child_rd_en) begin
            child_rd_reg <= child_mem[slot_next];
        end
        if (child_wr_en) begin
            child_mem[slot_reg] <= new_node;
        end
    end

    // Node link memory.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_CHILD) begin
            link_rd_reg <= link_mem[child_rd_reg];
        end
        if (link_wr_en) begin
            link_mem[new_node] <= want_link;
        end
    end

    // Node tag memory.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_CHILD) begin
            tag_rd_reg <= tag_mem[child_rd_reg];
        end
        if (tag_wr_en) begin
            tag_mem[tag_wr_addr] <= tag_wr_data;
        end
    end

    // Result register: loaded only while empty or being taken.
    assign m_valid_next = res_load || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (res_load) begin
            m_match_valid_reg <= res_match;
            m_match_id_reg    <= res_id;
            m_walk_ended_reg  <= res_ended;
            m_table_full_reg  <= res_full;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_match_valid = m_match_valid_reg;
    assign m_match_id    = m_match_id_reg;
    assign m_walk_ended  = m_walk_ended_reg;
    assign m_table_full  = m_table_full_reg;

endmodule

// ===== design/tpm_checker.sv =====
// ----------------------------------------------------------------------------
// tpm_checker: port-level checks for the trie pattern matcher
// Watches the result channel for consistent flags and a held result.
// ----------------------------------------------------------------------------
module tpm_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic                         m_match_valid,
    input logic [tpm_pkg::ID_W-1:0]     m_match_id,
    input logic                         m_walk_ended,
    input logic                         m_table_full
);
    import tpm_pkg::*;

    // No result is offered in the cycle after reset.
    a_idle_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result offered right after reset");

    // A stalled result holds its payload.
    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_match_valid)
            && $stable(m_match_id) && $stable(m_walk_ended) && $stable(m_table_full))
        else $error("stalled result changed");

    // A full table is reported only on insert, so never with scan flags.
    a_full_is_insert: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_table_full |-> !m_match_valid && !m_walk_ended)
        else $error("table full reported together with scan flags");

    // A match means the walk is still going.
    a_match_not_ended: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_match_valid |-> !m_walk_ended)
        else $error("match reported on an ended walk");

    // Without a match the id reads zero.
    a_id_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_match_valid |-> m_match_id == '0)
        else $error("nonzero id without a match");

endmodule

bind trie_pattern_match tpm_checker u_tpm_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_match_valid (m_match_valid),
    .m_match_id    (m_match_id),
    .m_walk_ended  (m_walk_ended),
    .m_table_full  (m_table_full)
);

// ===== tb/tb_trie_pattern_match.sv =====
// ----------------------------------------------------------------------------
// tb_trie_pattern_match: self-checking testbench for the trie pattern matcher
// A shadow copy of the node table predicts the one result that each accepted
// letter gives. Stimulus runs in two phases: a short directed set of corner
// cases, then random well-formed insert and scan sequences with some noise.
// The sender works in bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb_trie_pattern_match;

    timeunit 1ns;
    timeprecision 1ps;

    import tpm_pkg::*;

    localparam int CYCLE_LIMIT  = 800_000;
    localparam int RANDOM_ITEMS = 1200;
    localparam int BANK_SIZE    = 64;
    localparam int MAX_PATTERN  = 12;
    localparam int SETTLE_CYCLES = 20;

    // One result transfer, in port order.
    typedef struct packed {
        logic            match_valid;
        logic [ID_W-1:0] match_id;
        logic            walk_ended;
        logic            table_full;
    } match_report_t;

    // Receiver stall modes.
    typedef enum int {
        RDY_OPEN,
        RDY_COIN,
        RDY_HOLD,
        RDY_SPARSE
    } ready_mode_t;

    // Shadow copy of the trie; predicts and checks the match reports.
    class trie_shadow;
        logic [NODE_W-1:0] child_of  [SLOT_COUNT];
        logic              is_tagged [NODE_COUNT];
        logic [ID_W-1:0]   tag_id    [NODE_COUNT];
        int                used;
        logic [NODE_W-1:0] cursor;
        logic              stopped;
        match_report_t     awaited[$];
        int                error_count;

        function new();
            foreach (child_of[i]) child_of[i] = '0;
            foreach (is_tagged[i]) begin
                is_tagged[i] = 1'b0;
                tag_id[i]    = '0;
            end
            used        = 1;
            cursor      = '0;
            stopped     = 1'b0;
            error_count = 0;
        endfunction

        // Walk one accepted letter and queue the report it must produce.
        function void take_letter(logic req_type, logic [LETTER_W-1:0] letter,
                                  logic first, logic last, logic [ID_W-1:0] pid);
            match_report_t     r;
            int                slot;
            logic [NODE_W-1:0] child;
            r = '0;
            if (first) begin
                cursor  = '0;
                stopped = 1'b0;
            end
            if (req_type == REQ_INSERT) begin
                if (stopped) begin
                    r.table_full = 1'b1;
                end else if (letter < LETTER_COUNT) begin
                    slot  = int'(cursor) * LETTER_COUNT + int'(letter);
                    child = child_of[slot];
                    if (child == '0) begin
                        if (used < NODE_COUNT) begin
                            child          = NODE_W'(used);
                            child_of[slot] = child;
                            used++;
                        end else begin
                            stopped      = 1'b1;
                            r.table_full = 1'b1;
                        end
                    end
                    if (!stopped) begin
                        cursor = child;
                        if (last) begin
                            is_tagged[cursor] = 1'b1;
                            tag_id[cursor]    = pid;
                        end
                    end
                end
            end else begin
                if (!stopped) begin
                    if (letter < LETTER_COUNT)
                        child = child_of[int'(cursor) * LETTER_COUNT + int'(letter)];
                    else
                        child = '0;
                    if (child == '0) begin
                        stopped = 1'b1;
                    end else begin
                        cursor = child;
                        if (is_tagged[cursor]) begin
                            r.match_valid = 1'b1;
                            r.match_id    = tag_id[cursor];
                        end
                    end
                end
                r.walk_ended = stopped;
            end
            awaited.insert(awaited.size(), r);
        endfunction

        // Compare one result transfer with the oldest queued report.
        function void compare_report(match_report_t got);
            match_report_t want;
            if (awaited.size() == 0) begin
                error_count++;
                if (error_count <= 10)
                    $display({"unexpected result: match_valid=%0d match_id=%0d ",
                              "walk_ended=%0d table_full=%0d"},
                             got.match_valid, got.match_id, got.walk_ended,
                             got.table_full);
                return;
            end
            want = awaited.pop_front();
            if (got !== want) begin
                error_count++;
                if (error_count <= 10)
                    $display({"mismatch: expected %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d ",
                              "(valid/id/ended/full)"},
                             want.match_valid, want.match_id, want.walk_ended,
                             want.table_full, got.match_valid, got.match_id,
                             got.walk_ended, got.table_full);
            end
        endfunction
    endclass

    logic                aclk           = 1'b0;
    logic                aresetn        = 1'b0;
    logic                s_valid        = 1'b0;
    logic                s_ready;
    logic                s_req_type     = REQ_INSERT;
    logic [LETTER_W-1:0] s_letter       = '0;
    logic                s_first_letter = 1'b0;
    logic                s_last_letter  = 1'b0;
    logic [ID_W-1:0]     s_pattern_id   = '0;
    logic                m_valid;
    logic                m_ready        = 1'b0;
    logic                m_match_valid;
    logic [ID_W-1:0]     m_match_id;
    logic                m_walk_ended;
    logic                m_table_full;

    trie_shadow shadow = new();

    int burst_left   = 0;
    int useful_items = 0;
    int cycle_count  = 0;

    // Patterns inserted so far, replayed by scans.
    logic [LETTER_W-1:0] bank_letters [BANK_SIZE][MAX_PATTERN];
    int                  bank_len     [BANK_SIZE];
    int                  bank_count   = 0;

    trie_pattern_match i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_letter       (s_letter),
        .s_first_letter (s_first_letter),
        .s_last_letter  (s_last_letter),
        .s_pattern_id   (s_pattern_id),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_match_valid  (m_match_valid),
        .m_match_id     (m_match_id),
        .m_walk_ended   (m_walk_ended),
        .m_table_full   (m_table_full)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Check every result transfer at the rising edge.
    always @(posedge aclk) begin : result_monitor
        match_report_t got;
        if (aresetn && m_valid && m_ready) begin
            got = {m_match_valid, m_match_id, m_walk_ended, m_table_full};
            shadow.compare_report(got);
        end
    end

    // Receiver back-pressure: segments of open, coin-flip, held and sparse ready.
    always @(negedge aclk) begin : ready_pattern
        static ready_mode_t mode = RDY_OPEN;
        static int          hold_left = 0;
        if (hold_left == 0) begin
            mode      = ready_mode_t'($urandom_range(0, 3));
            hold_left = $urandom_range(4, 32);
        end
        hold_left--;
        case (mode)
            RDY_OPEN:   m_ready <= 1'b1;
            RDY_COIN:   m_ready <= 1'($urandom_range(0, 1));
            RDY_HOLD:   m_ready <= (hold_left < 4);
            default:    m_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // Run limit.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Present one letter and hold it until the transfer, with bursty gaps.
    task automatic send_letter(input logic rt, input logic [LETTER_W-1:0] letter,
                               input logic first, input logic last,
                               input logic [ID_W-1:0] pid);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                @(negedge aclk);
                s_valid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        @(negedge aclk);
        s_valid        <= 1'b1;
        s_req_type     <= rt;
        s_letter       <= letter;
        s_first_letter <= first;
        s_last_letter  <= last;
        s_pattern_id   <= pid;
        do @(posedge aclk); while (!s_ready);
        shadow.take_letter(rt, letter, first, last, pid);
        burst_left--;
        if (!(rt == REQ_INSERT && letter >= LETTER_COUNT))
            useful_items++;
    endtask

    // Stop sending until every queued report has come back.
    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        burst_left = 0;
        while (shadow.awaited.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // One random sequence: mostly whole patterns and scans, some noise.
    task automatic send_random_sequence();
        int                  kind;
        int                  len;
        int                  alpha_hi;
        int                  pick;
        int                  extra;
        int                  slot;
        logic [ID_W-1:0]     pid;
        logic [LETTER_W-1:0] letter;
        logic [LETTER_W-1:0] text [MAX_PATTERN + 4];
        kind = $urandom_range(0, 99);
        if (kind < 40) begin
            // Insert a whole pattern; small alphabets make shared prefixes.
            len      = ($urandom_range(0, 7) == 0) ? $urandom_range(7, MAX_PATTERN)
                                                    : $urandom_range(1, 4);
            alpha_hi = ($urandom_range(0, 3) == 0) ? LETTER_COUNT - 1 : 3;
            pid      = ID_W'($urandom_range(0, 1023));
            if (bank_count < BANK_SIZE) begin
                slot = bank_count;
                bank_count++;
            end else begin
                slot = $urandom_range(0, BANK_SIZE - 1);
            end
            bank_len[slot] = len;
            for (int i = 0; i < len; i++) begin
                letter = LETTER_W'($urandom_range(0, alpha_hi));
                bank_letters[slot][i] = letter;
                if (i > 0 && $urandom_range(0, 24) == 0)
                    send_letter(REQ_INSERT, LETTER_W'($urandom_range(LETTER_COUNT, 31)),
                                1'b0, 1'($urandom_range(0, 1)),
                                ID_W'($urandom_range(0, 1023)));
                send_letter(REQ_INSERT, letter, i == 0, i == len - 1, pid);
            end
        end else if (kind < 80) begin
            // Scan a known pattern or its prefix, maybe with a tail.
            if (bank_count > 0 && $urandom_range(0, 3) != 0) begin
                pick = $urandom_range(0, bank_count - 1);
                len  = ($urandom_range(0, 2) == 0) ? $urandom_range(1, bank_len[pick])
                                                    : bank_len[pick];
                for (int i = 0; i < len; i++)
                    text[i] = bank_letters[pick][i];
            end else begin
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++)
                    text[i] = LETTER_W'($urandom_range(0, 3));
            end
            extra = $urandom_range(0, 3);
            for (int i = 0; i < extra; i++) begin
                if ($urandom_range(0, 15) == 0)
                    text[len + i] = LETTER_W'($urandom_range(LETTER_COUNT, 31));
                else
                    text[len + i] = LETTER_W'($urandom_range(0, 3));
            end
            for (int i = 0; i < len + extra; i++)
                send_letter(REQ_SCAN, text[i], i == 0, 1'($urandom_range(0, 1)),
                            ID_W'($urandom_range(0, 1023)));
        end else if (kind < 90) begin
            // Continue from the shared cursor with mixed item types.
            len = $urandom_range(1, 4);
            for (int i = 0; i < len; i++)
                send_letter(1'($urandom_range(0, 1)),
                            ($urandom_range(0, 7) == 0) ? LETTER_W'($urandom_range(0, 31))
                                                        : LETTER_W'($urandom_range(0, 3)),
                            1'b0, 1'($urandom_range(0, 1)),
                            ID_W'($urandom_range(0, 1023)));
        end else begin
            send_letter(1'($urandom_range(0, 1)), LETTER_W'($urandom_range(0, 31)),
                        1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                        ID_W'($urandom_range(0, 1023)));
        end
    endtask

    initial begin
        int start;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed corner cases.
        send_letter(REQ_INSERT, 5'd0,  1'b1, 1'b0, 10'd0);
        send_letter(REQ_INSERT, 5'd1,  1'b0, 1'b1, 10'd0);
        send_letter(REQ_INSERT, 5'd25, 1'b1, 1'b1, 10'd1023);
        // Out-of-range letters are ignored, but a start mark still resets the walk,
        // so the root stays untagged.
        send_letter(REQ_INSERT, 5'd31, 1'b1, 1'b1, 10'h2AA);
        send_letter(REQ_INSERT, 5'd26, 1'b0, 1'b1, 10'h2AA);
        send_letter(REQ_INSERT, 5'd0,  1'b0, 1'b1, 10'h155);
        send_letter(REQ_SCAN,   5'd0,  1'b1, 1'b0, 10'd0);
        send_letter(REQ_SCAN,   5'd1,  1'b0, 1'b0, 10'd0);
        send_letter(REQ_SCAN,   5'd2,  1'b0, 1'b0, 10'd0);
        send_letter(REQ_SCAN,   5'd0,  1'b0, 1'b1, 10'd1023);
        send_letter(REQ_SCAN,   5'd25, 1'b1, 1'b0, 10'd0);
        send_letter(REQ_SCAN,   5'd31, 1'b1, 1'b0, 10'd0);
        // Duplicate pattern: the later id wins.
        send_letter(REQ_INSERT, 5'd0,  1'b1, 1'b0, 10'd7);
        send_letter(REQ_INSERT, 5'd1,  1'b0, 1'b1, 10'd512);
        send_letter(REQ_SCAN,   5'd0,  1'b1, 1'b0, 10'd0);
        send_letter(REQ_SCAN,   5'd1,  1'b0, 1'b0, 10'd0);
        // An insert continues from where the scan left the shared cursor.
        send_letter(REQ_INSERT, 5'd2,  1'b0, 1'b1, 10'd1000);
        send_letter(REQ_SCAN,   5'd0,  1'b1, 1'b0, 10'd0);
        send_letter(REQ_SCAN,   5'd1,  1'b0, 1'b0, 10'd0);
        send_letter(REQ_SCAN,   5'd2,  1'b0, 1'b0, 10'd0);
        // A stopped scan walk makes a following insert report a full table.
        send_letter(REQ_SCAN,   5'd16, 1'b1, 1'b0, 10'd0);
        send_letter(REQ_INSERT, 5'd0,  1'b0, 1'b1, 10'd3);
        send_letter(REQ_SCAN,   5'd25, 1'b1, 1'b1, 10'd1023);
        wait_drained();

        // Random sequences.
        start = useful_items;
        while (useful_items < start + RANDOM_ITEMS)
            send_random_sequence();

        wait_drained();
        if (shadow.error_count == 0 && shadow.awaited.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
